// ===== hw/rtl/ima_adpcm_block_encoder_defines.svh =====
`ifndef IMA_ADPCM_BLOCK_ENCODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_ENCODER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define IABE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("iabe assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define IABE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iabe assertion failed");

`endif

// ===== hw/rtl/iabe_pkg.sv =====
`timescale 1ns / 1ps

package iabe_pkg;

	localparam int unsigned MAX_BLOCK_SAMPLES = 4096;
	localparam int unsigned LEN_W             = 13;
	localparam logic [LEN_W-1:0] BLOCK_SAMPLES_RST = 13'd505;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BLOCK_SAMPLES);
	localparam logic [6:0] IDX_MAX = 7'd88;
	localparam logic [1:0] HDR_LEFT_AFTER_FIRST = 2'd3;

	localparam logic [14:0] STEP_TAB [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41,
		15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97,
		15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209,
		15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449,
		15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963,
		15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878,
		15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660,
		15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132,
		15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794, 15'd32767
	};

	function automatic logic [14:0] step_size(input logic [6:0] idx);
		logic [14:0] s;
		if (idx > IDX_MAX) begin
			s = STEP_TAB[IDX_MAX];
		end else begin
			s = STEP_TAB[idx];
		end
		return s;
	endfunction

	typedef struct packed {
		logic [3:0]        code;
		logic signed [15:0] pred;
		logic [6:0]        idx;
	} quant_t;

endpackage

// ===== hw/rtl/iabe_quant.sv =====
`timescale 1ns / 1ps

module iabe_quant (
	input  logic signed [15:0] sample,
	input  logic signed [15:0] pred,
	input  logic [6:0]         idx,
	output iabe_pkg::quant_t   res
);

	logic [14:0]        step;
	logic signed [16:0] diff;
	logic               neg;
	logic [16:0]        mag, s0, s1, s2, r1, r2, dq;
	logic               b2, b1, b0;
	logic signed [17:0] p;
	logic [2:0]         up;
	logic [6:0]         ni;

	always_comb begin
		step = iabe_pkg::step_size(idx);
		diff = {sample[15], sample} - {pred[15], pred};
		neg  = diff[16];
		mag  = neg ? 17'(-diff) : 17'(diff);
		s0   = {2'b0, step};
		s1   = {3'b0, step[14:1]};
		s2   = {4'b0, step[14:2]};

		b2 = mag >= s0;
		r1 = b2 ? mag - s0 : mag;
		b1 = r1 >= s1;
		r2 = b1 ? r1 - s1 : r1;
		b0 = r2 >= s2;

		dq = {5'b0, step[14:3]} + (b2 ? s0 : 17'd0) + (b1 ? s1 : 17'd0)
			+ (b0 ? s2 : 17'd0);
		p  = neg ? ({{2{pred[15]}}, pred} - {1'b0, dq})
			: ({{2{pred[15]}}, pred} + {1'b0, dq});

		if (p < -18'sd32768) begin
			res.pred = 16'sh8000;
		end else if (p > 18'sd32767) begin
			res.pred = 16'sh7fff;
		end else begin
			res.pred = p[15:0];
		end
		res.code = {neg, b2, b1, b0};

		// magnitude codes 4..7 step up by 2,4,6,8; 0..3 step down by one
		up = {1'b0, b1, b0} + 3'd1;
		if (b2) begin
			ni = idx + {3'b0, up, 1'b0};
		end else if (idx == 7'd0) begin
			ni = 7'd0;
		end else begin
			ni = idx - 7'd1;
		end
		res.idx = (ni > iabe_pkg::IDX_MAX) ? iabe_pkg::IDX_MAX : ni;
	end

endmodule

// ===== hw/rtl/ima_adpcm_block_encoder.sv =====
`timescale 1ns / 1ps
// IMA ADPCM 4-bit block encoder.
// Input channel (in_valid/in_ready): one signed 16-bit PCM sample per word, with
// end_of_stream marking the last sample. Output channel (out_valid/out_ready):
// one encoded byte per word, with last_of_run on the final byte caused by a
// sample and block_end on the final byte of a block.
// Config channel (cfg_valid/cfg_ready): block_samples, always ready; write it
// only while the encoder is idle.
// A sample is registered on acceptance and encoded into the output register
// when that register is free and no header is pending; its first byte is then offered.
// Later samples go through at one per cycle while out_ready is high; a block start
// emits a 4-byte header (predictor low, predictor high, index 0, zero), during which
// the encode stage stalls and the input takes at most one more word.
// The first sample of a block gives the header; later samples that complete a
// nibble pair, or close a block, give one byte; others give none.
// When out_ready is low the output register holds its word and the input
// register fills, then in_ready drops.
// Reset clears the predictor, step index and block position (next sample
// starts a block) and sets block_samples to 505.
`include "ima_adpcm_block_encoder_defines.svh"

module ima_adpcm_block_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [iabe_pkg::LEN_W-1:0]   block_samples,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           sample,
	input  logic                         end_of_stream,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_byte,
	output logic                         last_of_run,
	output logic                         block_end
);

	logic [iabe_pkg::LEN_W-1:0] blk_len_q, len, pos_q, pos_inc;
	logic signed [15:0]         pred_q;
	logic [6:0]                 idx_q;
	logic [3:0]                 held_q;
	logic                       held_vld_q;
	logic                       valid_s1;
	logic signed [15:0]         sample_s1;
	logic                       eos_s1;
	logic [1:0]                 hdr_left_q;
	logic [7:0]                 hdr_hi_q;
	logic                       hdr_close_q;
	logic                       out_valid_q, last_q, bend_q;
	logic [7:0]                 byte_q;

	iabe_pkg::quant_t q;
	logic out_free, hdr_busy, s1_take, first, close;
	logic emit, emit_last, emit_bend;
	logic [7:0] emit_byte;

	iabe_quant u_quant (
		.sample (sample_s1),
		.pred   (pred_q),
		.idx    (idx_q),
		.res    (q)
	);

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;
	assign block_end   = bend_q;

	assign out_free = !out_valid_q || out_ready;
	assign hdr_busy = hdr_left_q != 2'd0;
	assign s1_take  = valid_s1 && out_free && !hdr_busy;
	assign in_ready = !valid_s1 || s1_take;

	always_comb begin
		if (blk_len_q == '0) begin
			len = iabe_pkg::LEN_W'(1);
		end else if (blk_len_q > iabe_pkg::LEN_MAX) begin
			len = iabe_pkg::LEN_MAX;
		end else begin
			len = blk_len_q;
		end
		first   = pos_q == '0;
		pos_inc = pos_q + iabe_pkg::LEN_W'(1);
		close   = first ? (eos_s1 || len <= iabe_pkg::LEN_W'(1))
			: (eos_s1 || pos_inc >= len);

		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_last = 1'b0;
		emit_bend = 1'b0;
		if (first) begin
			emit      = 1'b1;
			emit_byte = sample_s1[7:0];
		end else if (!held_vld_q) begin
			emit      = close;
			emit_byte = {4'd0, q.code};
			emit_last = 1'b1;
			emit_bend = 1'b1;
		end else begin
			emit      = 1'b1;
			emit_byte = {q.code, held_q};
			emit_last = 1'b1;
			emit_bend = close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= iabe_pkg::BLOCK_SAMPLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			blk_len_q <= block_samples;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
			eos_s1    <= end_of_stream;
		end
	end

	// encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q     <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (s1_take) begin
			if (first) begin
				pred_q     <= sample_s1;
				idx_q      <= '0;
				held_q     <= '0;
				held_vld_q <= 1'b0;
				pos_q      <= close ? '0 : iabe_pkg::LEN_W'(1);
			end else begin
				pred_q <= q.pred;
				idx_q  <= q.idx;
				if (close || held_vld_q) begin
					held_q     <= '0;
					held_vld_q <= 1'b0;
				end else begin
					held_q     <= q.code;
					held_vld_q <= 1'b1;
				end
				pos_q <= close ? '0 : pos_inc;
			end
		end
	end

	// header sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			if (hdr_busy) begin
				hdr_left_q  <= hdr_left_q - 2'd1;
				out_valid_q <= 1'b1;
			end else if (s1_take && emit) begin
				hdr_left_q  <= first ? iabe_pkg::HDR_LEFT_AFTER_FIRST : 2'd0;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hdr_busy) begin
				byte_q <= (hdr_left_q == iabe_pkg::HDR_LEFT_AFTER_FIRST) ? hdr_hi_q : 8'd0;
				last_q <= hdr_left_q == 2'd1;
				bend_q <= (hdr_left_q == 2'd1) && hdr_close_q;
			end else if (s1_take && emit) begin
				byte_q <= emit_byte;
				last_q <= emit_last;
				bend_q <= emit_bend;
			end
		end
		if (s1_take && first) begin
			hdr_hi_q    <= sample_s1[15:8];
			hdr_close_q <= close;
		end
	end

	`IABE_ASSERT(a_hdr_blocks_encode, !(hdr_busy && s1_take))
	`IABE_ASSERT(a_idx_range, idx_q <= iabe_pkg::IDX_MAX)
	`IABE_ASSERT(a_held_in_block, !held_vld_q || pos_q != '0)
	`IABE_ASSERT_NEXT(a_hdr_last, out_free && hdr_left_q == 2'd1, last_of_run && out_valid)

endmodule

// ===== tb/tb_ima_adpcm_block_encoder.sv =====
`timescale 1ns / 1ps

module tb_ima_adpcm_block_encoder;

	localparam int LEN_CAP       = iabe_pkg::MAX_BLOCK_SAMPLES;
	localparam int RST_BLOCK_LEN = 505;
	localparam int IDX_TOP       = 88;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LONG_HOLD     = 300;

	localparam int ima_step [0:88] = '{
		7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41,
		45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190,
		209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724,
		796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272,
		2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132,
		7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
		20350, 22385, 24623, 27086, 29794, 32767
	};
	// index shift by magnitude bits of the code
	localparam int idx_shift [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

	typedef struct {
		logic signed [15:0] pcm;
		logic               last;
	} pcm_word_t;

	typedef struct {
		logic [7:0] b;
		logic       run_end;
		logic       blk_end;
	} enc_byte_t;

	typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_JAMMED, RX_PERIODIC} rx_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [iabe_pkg::LEN_W-1:0]  block_samples = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [15:0]          sample = '0;
	logic                        end_of_stream = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [7:0]                  out_byte;
	logic                        last_of_run;
	logic                        block_end;

	ima_adpcm_block_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.block_samples (block_samples),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.block_end     (block_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// encoder state as seen by the checker
	logic [iabe_pkg::LEN_W-1:0] len_reg = iabe_pkg::LEN_W'(RST_BLOCK_LEN);
	int         adpcm_pred = 0;
	int         adpcm_idx = 0;
	int         blk_pos = 0;
	logic [3:0] held_code = 4'h0;
	logic       nib_waiting = 1'b0;

	pcm_word_t pcm_backlog [$];
	enc_byte_t bytes_due [$];

	int errors = 0;
	int pcm_taken = 0;
	int bytes_checked = 0;
	int headers_seen = 0;
	int lens_used = 0;
	int walk_val = 0;
	int rx_hold_reqs = 0;
	logic in_took = 1'b0;

	function automatic void push_byte(input logic [7:0] b, input logic run_end,
			input logic blk_end);
		enc_byte_t e;
		e.b = b;
		e.run_end = run_end;
		e.blk_end = blk_end;
		bytes_due.push_back(e);
	endfunction

	function automatic void encode_pcm(input logic signed [15:0] s, input logic eos);
		int span, diff, stp, dq, p;
		logic [3:0] code;
		logic close;
		span = int'(len_reg);
		if (span == 0) span = 1;
		if (span > LEN_CAP) span = LEN_CAP;

		if (blk_pos == 0) begin
			close = eos || span <= 1;
			adpcm_pred = int'(s);
			adpcm_idx = 0;
			held_code = 4'h0;
			nib_waiting = 1'b0;
			headers_seen++;
			push_byte(s[7:0], 1'b0, 1'b0);
			push_byte(s[15:8], 1'b0, 1'b0);
			push_byte(8'h00, 1'b0, 1'b0);
			push_byte(8'h00, 1'b1, close);
			blk_pos = close ? 0 : 1;
			return;
		end

		stp = ima_step[adpcm_idx];
		diff = int'(s) - adpcm_pred;
		dq = stp >>> 3;
		code = 4'h0;
		if (diff < 0) begin
			code[3] = 1'b1;
			diff = -diff;
		end
		if (diff >= stp) begin
			code[2] = 1'b1;
			diff -= stp;
			dq += stp;
		end
		stp = stp >>> 1;
		if (diff >= stp) begin
			code[1] = 1'b1;
			diff -= stp;
			dq += stp;
		end
		stp = stp >>> 1;
		if (diff >= stp) begin
			code[0] = 1'b1;
			dq += stp;
		end
		p = code[3] ? adpcm_pred - dq : adpcm_pred + dq;
		if (p < -32768) p = -32768;
		if (p > 32767) p = 32767;
		adpcm_pred = p;
		adpcm_idx += idx_shift[code[2:0]];
		if (adpcm_idx < 0) adpcm_idx = 0;
		if (adpcm_idx > IDX_TOP) adpcm_idx = IDX_TOP;

		blk_pos++;
		close = eos || blk_pos >= span;
		if (!nib_waiting) begin
			held_code = code;
			nib_waiting = 1'b1;
			// odd code at block close goes out alone, high nibble zero
			if (close) push_byte({4'h0, code}, 1'b1, 1'b1);
		end else begin
			push_byte({code, held_code}, 1'b1, close);
			held_code = 4'h0;
			nib_waiting = 1'b0;
		end
		if (close) begin
			blk_pos = 0;
			held_code = 4'h0;
			nib_waiting = 1'b0;
		end
	endfunction

	// output check first, so a word accepted this edge cannot match its own bytes
	always @(posedge clk) begin : monitor
		enc_byte_t want;
		in_took <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected byte %02h last=%0b bend=%0b", $realtime,
							out_byte, last_of_run, block_end);
				end else begin
					want = bytes_due.pop_front();
					bytes_checked++;
					if (out_byte !== want.b || last_of_run !== want.run_end ||
							block_end !== want.blk_end) begin
						errors++;
						if (errors <= 10)
							$display("%0t: byte %0d exp %02h/%0b/%0b got %02h/%0b/%0b",
								$realtime, bytes_checked, want.b, want.run_end,
								want.blk_end, out_byte, last_of_run, block_end);
					end
				end
			end
			if (cfg_valid && cfg_ready) len_reg = block_samples;
			if (in_valid && in_ready) begin
				encode_pcm(sample, end_of_stream);
				pcm_taken++;
			end
		end
	end

	// sender: bursts of words with random gaps
	int tx_burst_left = 0;
	int tx_gap_left = 0;

	always @(negedge clk) begin : pcm_driver
		pcm_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (tx_gap_left > 0) begin
				tx_gap_left--;
				in_valid <= 1'b0;
			end else if (pcm_backlog.size() > 0) begin
				w = pcm_backlog.pop_front();
				sample <= w.pcm;
				end_of_stream <= w.last;
				in_valid <= 1'b1;
				if (tx_burst_left > 0) begin
					tx_burst_left--;
				end else begin
					tx_burst_left = $urandom_range(1, 24);
					tx_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches now and then, plus requested long hold-offs
	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left = 0;
	int rx_hold_left = 0;
	int rx_hold_seen = 0;
	int rx_tick = 0;

	always @(negedge clk) begin : byte_sink
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_tick++;
			if (rx_hold_seen != rx_hold_reqs) begin
				rx_hold_seen = rx_hold_reqs;
				rx_hold_left = LONG_HOLD;
			end
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 96);
			end else begin
				rx_mode_left--;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_BUSY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_JAMMED: out_ready <= ($urandom_range(0, 9) < 3);
					default: out_ready <= (rx_tick % 3 != 0);
				endcase
			end
		end
	end

	function automatic void offer(input logic signed [15:0] pcm, input logic last);
		pcm_word_t w;
		w.pcm = pcm;
		w.last = last;
		pcm_backlog.push_back(w);
	endfunction

	// mostly a random walk, with jumps, full-range noise and rail values
	function automatic logic signed [15:0] pcm_walk();
		int v;
		case ($urandom_range(0, 9))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
			2, 3: v = walk_val + int'($urandom_range(0, 8000)) - 4000;
			default: v = walk_val + int'($urandom_range(0, 200)) - 100;
		endcase
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		walk_val = v;
		return v[15:0];
	endfunction

	task automatic settle();
		while (pcm_backlog.size() != 0 || in_valid || bytes_due.size() != 0)
			@(posedge clk);
		// a held nibble produces nothing, so give the pipe time to empty
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_block_len(input int unsigned n);
		@(negedge clk);
		cfg_valid <= 1'b1;
		block_samples <= n[iabe_pkg::LEN_W-1:0];
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		lens_used++;
	endtask

	initial begin : limit
		#2000000;
		$display("[ima_adpcm_block_encoder] ERROR");
		$finish;
	end

	initial begin : stimulus
		int n;
		int lens [0:5];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset length: rail-to-rail swings drive the index and predictor into clamps
		offer(16'sh7FFF, 1'b0);
		for (int i = 0; i < 12; i++)
			offer((i % 2 == 0) ? 16'sh8000 : 16'sh7FFF, 1'b0);
		offer(16'sh0000, 1'b1);
		offer(16'sh8000, 1'b1);
		offer(16'sh5555, 1'b0);
		offer(16'shAAAA, 1'b1);
		offer(16'shFFFF, 1'b0);
		offer(16'sh0001, 1'b0);
		offer(16'sh0000, 1'b1);
		settle();

		// one-sample blocks, and zero which behaves the same
		set_block_len(1);
		offer(16'sh1234, 1'b0);
		offer(16'shEDCB, 1'b1);
		offer(16'sh0F0F, 1'b0);
		settle();
		set_block_len(0);
		offer(16'shF0F0, 1'b0);
		offer(16'sh7FFF, 1'b0);
		offer(16'sh8000, 1'b1);
		settle();

		// length shrunk while a block is open: next sample closes it
		set_block_len(20);
		for (int i = 0; i < 10; i++) offer(pcm_walk(), 1'b0);
		settle();
		set_block_len(5);
		offer(pcm_walk(), 1'b0);
		offer(pcm_walk(), 1'b0);
		offer(pcm_walk(), 1'b1);
		settle();

		// oversized setting acts as the cap; this block ends on end_of_stream
		set_block_len(8191);
		for (int i = 0; i < 40; i++) offer(pcm_walk(), 1'b0);
		offer(pcm_walk(), 1'b1);
		settle();

		lens = '{2, 3, 7, 16, 33, 1};
		lens[5] = $urandom_range(1, 64);
		for (int k = 0; k < 6; k++) begin
			set_block_len(lens[k]);
			n = $urandom_range(25, 40);
			// receiver holds off while the sender keeps pushing
			if (k == 3) rx_hold_reqs++;
			for (int i = 0; i < n; i++)
				offer(pcm_walk(), ($urandom_range(0, 19) == 0));
			settle();
		end

		set_block_len(RST_BLOCK_LEN);
		for (int i = 0; i < 30; i++) offer(pcm_walk(), 1'b0);
		offer(pcm_walk(), 1'b1);
		settle();

		$display("run: %0d samples in %0d blocks, %0d bytes checked, %0d length writes",
			pcm_taken, headers_seen, bytes_checked, lens_used);
		if (errors == 0) begin
			$display("[ima_adpcm_block_encoder] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[ima_adpcm_block_encoder] ERROR");
		end
		$finish;
	end

endmodule
